@@ rtl/rngs_pkg.sv @@
package rngs_pkg;

    // element and accumulator sizes
    localparam int ELEMENT_WIDTH = 16;
    localparam int MAX_DIM       = 1024;
    localparam int SQ_W          = 2 * ELEMENT_WIDTH;
    localparam int SUM_W         = 42;
    localparam int SUM_SPLIT     = SUM_W / 2;
    localparam int DIM_W         = 11;
    localparam int INV_W         = 16;
    localparam int LIM_W         = 15;
    localparam int CFG_W         = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int ARG_W         = 34;
    localparam int P_W           = 62;
    localparam int OPA_W         = 31;
    localparam int OPB_W         = 32;
    localparam int EXP_W         = 8;
    localparam int MANT_W        = 16;
    localparam int FRAC_W        = 30;
    localparam int ACC_W         = 32;
    localparam int N_W           = 4;

    localparam logic [DIM_W-1:0] COUNT_MAX = {DIM_W{1'b1}};

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_DIM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_DEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ARG_LIM = 2'd2;

    // configuration reset values
    localparam logic [DIM_W-1:0] ROW_DIM_RST = 11'd64;
    localparam logic [INV_W-1:0] INV_DEN_RST = 16'd2048;
    localparam logic [LIM_W-1:0] ARG_LIM_RST = 15'd22528;

    // fixed-point constants
    localparam logic [OPB_W-1:0] LOG2E_Q31 = 32'd3098164009;
    localparam logic [OPB_W-1:0] LN2_Q32   = 32'd2977044472;
    localparam logic [OPA_W-1:0] ONE_Q30   = 31'h4000_0000;
    localparam logic [N_W-1:0]   SERIES_LAST = 4'd14;

    // shared multiplier operand selects
    localparam logic [2:0] MS_SUM_LO = 3'd0;
    localparam logic [2:0] MS_SUM_HI = 3'd1;
    localparam logic [2:0] MS_LOG2E  = 3'd2;
    localparam logic [2:0] MS_LN2    = 3'd3;
    localparam logic [2:0] MS_TERM   = 3'd4;
    localparam logic [2:0] MS_RECIP  = 3'd5;

    // result kinds
    localparam logic [1:0] RES_SHAPE = 2'd0;
    localparam logic [1:0] RES_OVF   = 2'd1;
    localparam logic [1:0] RES_VAL   = 2'd2;

    typedef struct packed {
        logic [2:0] mul_sel;
        logic       load_lo;
        logic       load_arg;
        logic       load_exp;
        logic       init_series;
        logic       load_q;
        logic       step_series;
        logic       res_load;
        logic [1:0] res_sel;
        logic       clr_row;
    } cmd_t;

    typedef struct packed {
        logic shape_bad;
        logic arg_over;
        logic series_done;
    } sts_t;

    // floor(2^31 / n) for the series divisors
    function automatic logic [OPB_W-1:0] recip_q31(input logic [N_W-1:0] n);
        logic [OPB_W-1:0] r;
        begin
            unique case (n)
                4'd1:    r = 32'd2147483648;
                4'd2:    r = 32'd1073741824;
                4'd3:    r = 32'd715827882;
                4'd4:    r = 32'd536870912;
                4'd5:    r = 32'd429496729;
                4'd6:    r = 32'd357913941;
                4'd7:    r = 32'd306783378;
                4'd8:    r = 32'd268435456;
                4'd9:    r = 32'd238609294;
                4'd10:   r = 32'd214748364;
                4'd11:   r = 32'd195225786;
                4'd12:   r = 32'd178956970;
                4'd13:   r = 32'd165191049;
                4'd14:   r = 32'd153391689;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

endpackage

@@ rtl/rngs_ctrl.sv @@
module rngs_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_last,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output rngs_pkg::cmd_t cmd,
    input  rngs_pkg::sts_t sts
);
    import rngs_pkg::*;

    localparam logic [3:0] ST_ACC   = 4'd0;
    localparam logic [3:0] ST_DRAIN = 4'd1;
    localparam logic [3:0] ST_CHK   = 4'd2;
    localparam logic [3:0] ST_MHI   = 4'd3;
    localparam logic [3:0] ST_ARG   = 4'd4;
    localparam logic [3:0] ST_LIM   = 4'd5;
    localparam logic [3:0] ST_FRAC  = 4'd6;
    localparam logic [3:0] ST_X     = 4'd7;
    localparam logic [3:0] ST_TM    = 4'd8;
    localparam logic [3:0] ST_TR    = 4'd9;
    localparam logic [3:0] ST_TC    = 4'd10;
    localparam logic [3:0] ST_RND   = 4'd11;
    localparam logic [3:0] ST_OUT   = 4'd12;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_ready  = (state_reg == ST_ACC);
    assign out_valid = (state_reg == ST_OUT);

    // sequencer for the row end work
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_sel = MS_SUM_LO;
        unique case (state_reg)
            ST_ACC:
            begin
                if (in_valid && in_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                if (sts.shape_bad)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_SHAPE;
                    state_next   = ST_OUT;
                end
                else
                begin
                    cmd.mul_sel = MS_SUM_LO;
                    state_next  = ST_MHI;
                end
            end
            ST_MHI:
            begin
                cmd.load_lo = 1'b1;
                cmd.mul_sel = MS_SUM_HI;
                state_next  = ST_ARG;
            end
            ST_ARG:
            begin
                cmd.load_arg = 1'b1;
                state_next   = ST_LIM;
            end
            ST_LIM:
            begin
                if (sts.arg_over)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_OVF;
                    state_next   = ST_OUT;
                end
                else
                begin
                    cmd.mul_sel = MS_LOG2E;
                    state_next  = ST_FRAC;
                end
            end
            ST_FRAC:
            begin
                cmd.load_exp = 1'b1;
                cmd.mul_sel  = MS_LN2;
                state_next   = ST_X;
            end
            ST_X:
            begin
                cmd.init_series = 1'b1;
                state_next      = ST_TM;
            end
            ST_TM:
            begin
                cmd.mul_sel = MS_TERM;
                state_next  = ST_TR;
            end
            ST_TR:
            begin
                cmd.load_q  = 1'b1;
                cmd.mul_sel = MS_RECIP;
                state_next  = ST_TC;
            end
            ST_TC:
            begin
                cmd.step_series = 1'b1;
                state_next      = sts.series_done ? ST_RND : ST_TM;
            end
            ST_RND:
            begin
                cmd.res_load = 1'b1;
                cmd.res_sel  = RES_VAL;
                state_next   = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    cmd.clr_row = 1'b1;
                    state_next  = ST_ACC;
                end
            end
            default:
            begin
                state_next = ST_ACC;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACC;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/rngs_dp.sv @@
module rngs_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [rngs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rngs_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                in_fire,
    input  logic [rngs_pkg::ELEMENT_WIDTH-1:0]  element,
    input  rngs_pkg::cmd_t                      cmd,
    output rngs_pkg::sts_t                      sts,
    output logic [rngs_pkg::EXP_W-1:0]          scale_exponent,
    output logic [rngs_pkg::MANT_W-1:0]         scale_mantissa,
    output logic                                overflow_flag,
    output logic                                shape_error
);
    import rngs_pkg::*;

    logic [DIM_W-1:0]  row_dim_reg;
    logic [INV_W-1:0]  inv_den_reg;
    logic [LIM_W-1:0]  arg_lim_reg;

    logic [ELEMENT_WIDTH-1:0] mag;
    logic [SQ_W-1:0]          sq_reg;
    logic                     sq_vld_reg;
    logic [SUM_W:0]           sum_add;
    logic [SUM_W-1:0]         sum_reg;
    logic [DIM_W-1:0]         count_reg;

    logic [OPA_W-1:0]   mul_a;
    logic [OPB_W-1:0]   mul_b;
    logic [P_W:0]       mul_full;
    logic [P_W-1:0]     p_reg;

    logic [INV_W+SUM_SPLIT-1:0] lo_reg;
    logic [INV_W+SUM_W-1:0]     arg_wide;
    logic [ARG_W-1:0]           arg_reg;
    logic [EXP_W-1:0]           exp_reg;

    logic [FRAC_W-1:0]  x_reg;
    logic [OPA_W-1:0]   term_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [N_W-1:0]     n_reg;
    logic [FRAC_W-1:0]  q_reg;
    logic [FRAC_W-1:0]  qt;
    logic [FRAC_W+N_W-1:0] qt_n;
    logic [FRAC_W+N_W-1:0] rem;
    logic [FRAC_W-1:0]  qt_fix;

    logic [ACC_W:0]       rnd;
    logic [MANT_W+1:0]    mant_rnd;

    logic [EXP_W-1:0]   res_exp_reg;
    logic [MANT_W-1:0]  res_mant_reg;
    logic               res_ovf_reg;
    logic               res_shape_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_dim_reg <= ROW_DIM_RST;
            inv_den_reg <= INV_DEN_RST;
            arg_lim_reg <= ARG_LIM_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_ROW_DIM)
            begin
                row_dim_reg <= cfg_data[DIM_W-1:0];
            end
            if (cfg_index == CFG_INV_DEN)
            begin
                inv_den_reg <= cfg_data[INV_W-1:0];
            end
            if (cfg_index == CFG_ARG_LIM)
            begin
                arg_lim_reg <= cfg_data[LIM_W-1:0];
            end
        end
    end

    // magnitude and square of the incoming word
    assign mag = element[ELEMENT_WIDTH-1] ? (~element + 1'b1) : element;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            sq_reg <= SQ_W'(mag) * SQ_W'(mag);
        end
    end

    // saturating sum of squares and element count
    assign sum_add = {1'b0, sum_reg} + (SUM_W + 1)'(sq_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_vld_reg <= 1'b0;
            sum_reg    <= '0;
            count_reg  <= '0;
        end
        else
        begin
            sq_vld_reg <= in_fire;
            if (cmd.clr_row)
            begin
                sum_reg   <= '0;
                count_reg <= '0;
            end
            else
            begin
                if (sq_vld_reg)
                begin
                    sum_reg <= sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
                end
                if (in_fire && (count_reg != COUNT_MAX))
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
        end
    end

    // shared multiplier operand select
    always_comb
    begin
        unique case (cmd.mul_sel)
            MS_SUM_LO:
            begin
                mul_a = OPA_W'(sum_reg[SUM_SPLIT-1:0]);
                mul_b = OPB_W'(inv_den_reg);
            end
            MS_SUM_HI:
            begin
                mul_a = OPA_W'(sum_reg[SUM_W-1:SUM_SPLIT]);
                mul_b = OPB_W'(inv_den_reg);
            end
            MS_LOG2E:
            begin
                mul_a = OPA_W'(arg_reg[22:0]);
                mul_b = LOG2E_Q31;
            end
            MS_LN2:
            begin
                mul_a = OPA_W'(p_reg[46:17]);
                mul_b = LN2_Q32;
            end
            MS_TERM:
            begin
                mul_a = term_reg;
                mul_b = OPB_W'(x_reg);
            end
            MS_RECIP:
            begin
                mul_a = OPA_W'(p_reg[59:30]);
                mul_b = recip_q31(n_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // registered product
    assign mul_full = (P_W + 1)'(mul_a) * (P_W + 1)'(mul_b);

    always_ff @(posedge clk)
    begin
        p_reg <= mul_full[P_W-1:0];
    end

    // argument assembly from the two partial products
    assign arg_wide = {p_reg[INV_W+SUM_SPLIT-1:0], {SUM_SPLIT{1'b0}}}
                      + (INV_W + SUM_W)'(lo_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load_lo)
        begin
            lo_reg <= p_reg[INV_W+SUM_SPLIT-1:0];
        end
        if (cmd.load_arg)
        begin
            arg_reg <= arg_wide[INV_W+SUM_W-1:24];
        end
        if (cmd.load_exp)
        begin
            exp_reg <= p_reg[54:47];
        end
    end

    // series divide by n: reciprocal estimate plus one correction
    assign qt     = p_reg[60:31];
    assign qt_n   = (FRAC_W + N_W)'(qt) * (FRAC_W + N_W)'(n_reg);
    assign rem    = (FRAC_W + N_W)'(q_reg) - qt_n;
    assign qt_fix = (rem >= (FRAC_W + N_W)'(n_reg)) ? (qt + 1'b1) : qt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg <= '0;
        end
        else if (cmd.init_series)
        begin
            n_reg <= 4'd1;
        end
        else if (cmd.step_series)
        begin
            n_reg <= n_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init_series)
        begin
            x_reg    <= p_reg[61:32];
            term_reg <= ONE_Q30;
            acc_reg  <= ACC_W'(ONE_Q30);
        end
        else if (cmd.step_series)
        begin
            term_reg <= OPA_W'(qt_fix);
            acc_reg  <= acc_reg + ACC_W'(qt_fix);
        end
        if (cmd.load_q)
        begin
            q_reg <= p_reg[59:30];
        end
    end

    // round half up to q1.15
    assign rnd      = {1'b0, acc_reg} + (ACC_W + 1)'(1 << 14);
    assign mant_rnd = rnd[ACC_W:15];

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            unique case (cmd.res_sel)
                RES_SHAPE:
                begin
                    res_exp_reg   <= '0;
                    res_mant_reg  <= '0;
                    res_ovf_reg   <= 1'b0;
                    res_shape_reg <= 1'b1;
                end
                RES_OVF:
                begin
                    res_exp_reg   <= '0;
                    res_mant_reg  <= '0;
                    res_ovf_reg   <= 1'b1;
                    res_shape_reg <= 1'b0;
                end
                RES_VAL:
                begin
                    if (mant_rnd[MANT_W+1:MANT_W] != 2'd0)
                    begin
                        res_exp_reg  <= exp_reg + 1'b1;
                        res_mant_reg <= 16'h8000;
                    end
                    else
                    begin
                        res_exp_reg  <= exp_reg;
                        res_mant_reg <= mant_rnd[MANT_W-1:0];
                    end
                    res_ovf_reg   <= 1'b0;
                    res_shape_reg <= 1'b0;
                end
                default:
                begin
                    res_exp_reg   <= '0;
                    res_mant_reg  <= '0;
                    res_ovf_reg   <= 1'b0;
                    res_shape_reg <= 1'b0;
                end
            endcase
        end
    end

    // status to the controller
    assign sts.shape_bad   = (count_reg != row_dim_reg)
                             || (row_dim_reg > DIM_W'(MAX_DIM));
    assign sts.arg_over    = arg_reg > ARG_W'({arg_lim_reg, 8'd0});
    assign sts.series_done = (n_reg == SERIES_LAST);

    assign scale_exponent = res_exp_reg;
    assign scale_mantissa = res_mant_reg;
    assign overflow_flag  = res_ovf_reg;
    assign shape_error    = res_shape_reg;

endmodule

@@ rtl/row_norm_gaussian_scale_top.sv @@
// channel  | handshake                      | payload
// ---------+--------------------------------+-------------------------------------------
// in       | s_axis_tvalid / s_axis_tready  | tdata: element_value; tlast: row_end
// out      | m_axis_tvalid / m_axis_tready  | tdata: exponent, mantissa; tuser: ovf, shape
// config   | cfg_we                         | cfg_index, cfg_data
//
// elements are taken one per clock while the sequencer is idle; each square goes through
// one registered multiplier and is added to the sum in the next cycle.
// after a row end word the sequencer runs on one shared 32x31 multiplier through the
// argument, its base-2 split, a series of 14 terms and the rounding; a shape error
// ends it at the shape check and an overflow at the limit check, then the result is shown.
// no input word is taken from the row end until the result word is taken.
// rst_n clears the sum, count, sequencer and loads the register reset values.
module row_norm_gaussian_scale_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] element_value
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] scale_exponent, [23:8] scale_mantissa
    output logic [1:0]  m_axis_tuser    // [0] overflow_flag, [1] shape_error
);
    import rngs_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic in_fire;
    logic [EXP_W-1:0]  scale_exponent;
    logic [MANT_W-1:0] scale_mantissa;
    logic overflow_flag;
    logic shape_error;

    assign in_fire = s_axis_tvalid && s_axis_tready;

    // sequencer
    rngs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_last   (s_axis_tlast),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // arithmetic
    rngs_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_fire        (in_fire),
        .element        (s_axis_tdata),
        .cmd            (cmd),
        .sts            (sts),
        .scale_exponent (scale_exponent),
        .scale_mantissa (scale_mantissa),
        .overflow_flag  (overflow_flag),
        .shape_error    (shape_error)
    );

    assign m_axis_tdata = {scale_mantissa, scale_exponent};
    assign m_axis_tuser = {shape_error, overflow_flag};

endmodule

@@ test/scale_checker.sv @@
module scale_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] element_value
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,   // [7:0] scale_exponent, [23:8] scale_mantissa
    input  logic [1:0]  m_axis_tuser,   // [0] overflow_flag, [1] shape_error
    output int          errors,
    output int          pending,
    output int          scaled_rows,
    output int          overflow_rows,
    output int          shape_rows
);
    import rngs_pkg::*;

    // fixed-point constants of the exponential
    localparam logic [63:0] LOG2E_FIX   = 64'd3098164009;   // log2(e) in Q1.31
    localparam logic [63:0] LN2_FIX     = 64'd2977044472;   // ln(2) in Q0.32
    localparam logic [63:0] UNIT_Q30    = 64'd1 << 30;
    localparam logic [63:0] FRAC47_MASK = (64'd1 << 47) - 64'd1;
    localparam logic [63:0] SUM_CEILING = (64'd1 << 42) - 64'd1;
    localparam logic [10:0] COUNT_CEIL  = 11'h7FF;
    localparam logic [10:0] DIM_CEILING = 11'd1024;

    typedef struct packed {
        logic [7:0]  exponent;
        logic [15:0] mantissa;
        logic        overflow;
        logic        shape;
    } scale_word_t;

    // shadow registers and row state
    logic [10:0]  row_dim;
    logic [15:0]  inv_den;
    logic [14:0]  arg_lim;
    logic [63:0]  sq_sum;
    logic [10:0]  elem_count;
    scale_word_t  expected_scales[$];

    // 2^f for f in [0,1) in Q0.30, Taylor series of exp(f*ln2), result in Q1.30
    function automatic logic [63:0] pow2_fraction_q30(input logic [63:0] f30);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] acc;
        int unsigned n;
        x    = (f30 * LN2_FIX) >> 32;
        term = UNIT_Q30;
        acc  = UNIT_Q30;
        for (n = 1; n <= 14; n++)
        begin
            term = ((term * x) >> 30) / n;
            acc  = acc + term;
        end
        return acc;
    endfunction

    // result word of a finished row
    function automatic scale_word_t predict_scale(
        input logic [63:0] sum,
        input logic [10:0] count,
        input logic [10:0] dim,
        input logic [15:0] inv,
        input logic [14:0] lim
    );
        scale_word_t w;
        logic [63:0] arg;
        logic [63:0] t;
        logic [63:0] e;
        logic [63:0] m;
        w = '0;
        if (count != dim || dim > DIM_CEILING)
        begin
            w.shape = 1'b1;
        end
        else
        begin
            arg = (sum * {48'd0, inv}) >> 24;
            if (arg > ({49'd0, lim} << 8))
            begin
                w.overflow = 1'b1;
            end
            else
            begin
                t = arg * LOG2E_FIX;
                e = t >> 47;
                m = (pow2_fraction_q30((t & FRAC47_MASK) >> 17) + 64'd16384) >> 15;
                // mantissa rounded up to 2.0 moves into the exponent
                if (m >= 64'd65536)
                begin
                    m = 64'd32768;
                    e = e + 64'd1;
                end
                w.exponent = e[7:0];
                w.mantissa = m[15:0];
            end
        end
        return w;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want_v);
        errors++;
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want_v);
    endtask

    // watch config, input and output channels
    always @(posedge clk)
    begin : watch
        scale_word_t want;
        logic [15:0] u;
        logic [63:0] mag;
        logic [63:0] sq;
        if (!rst_n)
        begin
            row_dim       = 11'd64;
            inv_den       = 16'd2048;
            arg_lim       = 15'd22528;
            sq_sum        = '0;
            elem_count    = '0;
            errors        = 0;
            scaled_rows   = 0;
            overflow_rows = 0;
            shape_rows    = 0;
            expected_scales.delete();
        end
        else
        begin
            // register writes, masked to register widths
            if (cfg_we)
            begin
                if (cfg_index == CFG_ROW_DIM)
                    row_dim = cfg_data[10:0];
                else if (cfg_index == CFG_INV_DEN)
                    inv_den = cfg_data;
                else if (cfg_index == CFG_ARG_LIM)
                    arg_lim = cfg_data[14:0];
            end

            // element word: saturating sum of squares and count
            if (s_axis_tvalid && s_axis_tready)
            begin
                u   = s_axis_tdata;
                mag = u[15] ? {48'd0, (~u + 16'd1)} : {48'd0, u};
                sq  = mag * mag;
                sq_sum = (sq > SUM_CEILING - sq_sum) ? SUM_CEILING : sq_sum + sq;
                if (elem_count < COUNT_CEIL)
                    elem_count = elem_count + 11'd1;
                if (s_axis_tlast)
                begin
                    expected_scales.push_back(
                        predict_scale(sq_sum, elem_count, row_dim, inv_den, arg_lim));
                    sq_sum     = '0;
                    elem_count = '0;
                end
            end

            // result word against the oldest row
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_scales.size() == 0)
                begin
                    report_mismatch("result word with no row pending", m_axis_tdata, 0);
                end
                else
                begin
                    want = expected_scales.pop_front();
                    if (m_axis_tdata[7:0] !== want.exponent)
                        report_mismatch("scale_exponent", m_axis_tdata[7:0], want.exponent);
                    if (m_axis_tdata[23:8] !== want.mantissa)
                        report_mismatch("scale_mantissa", m_axis_tdata[23:8], want.mantissa);
                    if (m_axis_tuser[0] !== want.overflow)
                        report_mismatch("overflow_flag", m_axis_tuser[0], want.overflow);
                    if (m_axis_tuser[1] !== want.shape)
                        report_mismatch("shape_error", m_axis_tuser[1], want.shape);
                    if (want.shape)
                        shape_rows++;
                    else if (want.overflow)
                        overflow_rows++;
                    else
                        scaled_rows++;
                end
            end
        end
        pending = expected_scales.size();
    end

endmodule

@@ test/tb_top.sv @@
module tb_top;
    import rngs_pkg::*;

    localparam logic [1:0] CFG_SPARE     = 2'd3;    // index with no register behind it
    localparam int         RANDOM_ITEMS  = 650;
    localparam int         SETTLE_CYCLES = 60;
    localparam int         HOLD_CYCLES   = 400;
    localparam int         HOLD_AT_WORD  = 15;
    localparam int         DRAIN_LIMIT   = 20000;

    // element styles for row content
    localparam int STYLE_FULL    = 0;
    localparam int STYLE_SMALL   = 1;
    localparam int STYLE_MEDIUM  = 2;
    localparam int STYLE_EXTREME = 3;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [15:0] element_value
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // [7:0] scale_exponent, [23:8] scale_mantissa
    logic [1:0]  m_axis_tuser;   // [0] overflow_flag, [1] shape_error

    int errors;
    int pending;
    int scaled_rows;
    int overflow_rows;
    int shape_rows;
    int words_sent;
    int words_taken;
    int random_words;
    int phases;
    bit no_idle;

    row_norm_gaussian_scale_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    scale_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .errors        (errors),
        .pending       (pending),
        .scaled_rows   (scaled_rows),
        .overflow_rows (overflow_rows),
        .shape_rows    (shape_rows)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit
    initial
    begin
        #4000000;
        $display("timeout: stimulus or result words stalled");
        $display("DONE: errors detected");
        $finish;
    end

    // result side: random stall per word, one long hold-off
    initial
    begin : result_sink
        int gap;
        words_taken = 0;
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = no_idle ? 0 : $urandom_range(0, 3);
            if (words_taken == HOLD_AT_WORD)
                gap = HOLD_CYCLES;
            if (gap != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            words_taken++;
        end
    end

    function automatic logic [15:0] pick_element(input int style);
        logic [31:0] r;
        logic [15:0] v;
        r = $urandom;
        case (style)
            STYLE_SMALL:  v = {8'd0, r[7:0]};
            STYLE_MEDIUM: v = {4'd0, r[11:0]};
            STYLE_EXTREME:
            begin
                case (r[18:16] % 5)
                    0:       v = 16'h8000;
                    1:       v = 16'h7FFF;
                    2:       v = 16'h0000;
                    3:       v = 16'hFFFF;
                    default: v = 16'h0001;
                endcase
            end
            default:      v = r[15:0];
        endcase
        // signed small and medium values
        if ((style == STYLE_SMALL || style == STYLE_MEDIUM) && r[31])
            v = -v;
        return v;
    endfunction

    task automatic send_word(input logic [15:0] value, input logic last);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tlast  <= last;
        do @(posedge clk); while (!s_axis_tready);
        words_sent++;
    endtask

    task automatic send_row(input int len, input int style);
        int i;
        for (i = 0; i < len; i++)
            send_word(pick_element(style), i == len - 1);
    endtask

    // register write, write enable left high for a following write
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // wait until every row result is back and the sequencer is idle
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // random phase: random settings, mostly rows of the right length
    task automatic random_phase();
        logic [31:0] r;
        logic [10:0] dim;
        logic [15:0] inv;
        logic [14:0] lim;
        int pick;
        int rows;
        int len;
        int i;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            r = $urandom_range(1, 16);
        else if (pick < 9)
            r = $urandom_range(17, 64);
        else
            r = $urandom_range(65, 200);
        dim = r[10:0];
        r   = $urandom_range(0, 65535) >> $urandom_range(0, 14);
        inv = r[15:0];
        r   = $urandom_range(0, 32767) >> $urandom_range(0, 8);
        lim = r[14:0];
        r   = $urandom;
        // upper data bits are junk that the registers must drop
        write_reg(CFG_ROW_DIM, {r[4:0], dim});
        write_reg(CFG_INV_DEN, inv);
        write_reg(CFG_ARG_LIM, {r[5], lim});
        if (r[9:8] == 2'd0)
            write_reg(CFG_SPARE, r[31:16]);
        cfg_we <= 1'b0;
        phases++;
        no_idle = ($urandom_range(0, 3) == 0);
        rows = (dim > 64) ? 2 : $urandom_range(3, 10);
        for (i = 0; i < rows; i++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 8)
                len = dim;
            else if (pick == 8)
                len = dim + 1;
            else
                len = (dim > 1) ? dim - 1 : $urandom_range(2, 20);
            send_row(len, $urandom_range(STYLE_FULL, STYLE_EXTREME));
            random_words += len;
        end
    endtask

    // stimulus and verdict
    initial
    begin : stimulus
        int i;
        int drain;
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_ROW_DIM;
        cfg_data      <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        no_idle       = 1'b0;
        words_sent    = 0;
        random_words  = 0;
        phases        = 1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset dimension of 64: a one word row is a shape error
        send_word(16'h8000, 1'b1);

        // dimension 4 with reset scale and limit
        settle();
        write_reg(CFG_ROW_DIM, 16'd4);
        cfg_we <= 1'b0;
        phases++;
        send_word(16'h8000, 1'b0);
        send_word(16'h7FFF, 1'b0);
        send_word(16'h0001, 1'b0);
        send_word(16'hFFFF, 1'b1);
        // zero row gives exp(0)
        for (i = 0; i < 4; i++)
            send_word(16'h0000, i == 3);
        // short and long rows
        send_word(16'h8000, 1'b0);
        send_word(16'h8000, 1'b1);
        for (i = 0; i < 5; i++)
            send_word(16'h7FFF, i == 4);

        // zero limit: tiny argument passes, large one overflows
        settle();
        write_reg(CFG_ARG_LIM, 16'd0);
        cfg_we <= 1'b0;
        phases++;
        for (i = 0; i < 4; i++)
            send_word((i == 0) ? 16'h0001 : 16'h0000, i == 3);
        for (i = 0; i < 4; i++)
            send_word(16'h8000, i == 3);

        // spare index ignored, masked dimension of 1025 is above the maximum
        settle();
        write_reg(CFG_SPARE, 16'hFFFF);
        write_reg(CFG_ROW_DIM, 16'hFC01);
        cfg_we <= 1'b0;
        phases++;
        send_word(16'h0100, 1'b1);

        // smallest settings, one word rows
        settle();
        write_reg(CFG_ROW_DIM, 16'd1);
        write_reg(CFG_INV_DEN, 16'd1);
        write_reg(CFG_ARG_LIM, 16'd0);
        cfg_we <= 1'b0;
        phases++;
        for (i = 0; i < 12; i++)
            send_row(1, i % 4);

        // largest dimension and limit
        settle();
        write_reg(CFG_ROW_DIM, 16'd1024);
        write_reg(CFG_INV_DEN, 16'd32768);
        write_reg(CFG_ARG_LIM, 16'd32767);
        cfg_we <= 1'b0;
        phases++;
        no_idle = 1'b1;
        send_row(1024, STYLE_SMALL);
        no_idle = 1'b0;

        // largest scale, arguments near the top of the range
        settle();
        write_reg(CFG_ROW_DIM, 16'd2);
        write_reg(CFG_INV_DEN, 16'hFFFF);
        cfg_we <= 1'b0;
        phases++;
        for (i = 0; i < 8; i++)
            send_row(2, i % 4);

        // all ones data: dimension 2047 and a row of largest magnitude words
        settle();
        write_reg(CFG_ROW_DIM, 16'hFFFF);
        write_reg(CFG_INV_DEN, 16'hFFFF);
        write_reg(CFG_ARG_LIM, 16'hFFFF);
        cfg_we <= 1'b0;
        phases++;
        no_idle = 1'b1;
        for (i = 0; i < 40; i++)
            send_word(16'h8000, i == 39);
        no_idle = 1'b0;
        send_row(3, STYLE_FULL);

        // zero dimension, zero scale, limit bit above the register dropped
        settle();
        write_reg(CFG_ROW_DIM, 16'h0800);
        write_reg(CFG_INV_DEN, 16'h0000);
        write_reg(CFG_ARG_LIM, 16'h8000);
        cfg_we <= 1'b0;
        phases++;
        for (i = 1; i <= 3; i++)
            send_row(i, STYLE_FULL);

        // random settings and rows
        while (random_words < RANDOM_ITEMS)
        begin
            settle();
            random_phase();
        end

        // drain
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        drain = 0;
        while (pending != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d element words over %0d register settings, with stalls and a hold-off",
                 words_sent, phases);
        $display("row results: %0d scaled, %0d overflow, %0d shape error",
                 scaled_rows, overflow_rows, shape_rows);
        if (pending != 0)
            $display("%0d expected result words never arrived", pending);
        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/rngs_pkg.sv
rtl/rngs_ctrl.sv
rtl/rngs_dp.sv
rtl/row_norm_gaussian_scale_top.sv
test/scale_checker.sv
test/tb_top.sv
